// ===== rtl/core/dscb_pkg.sv =====
// Shared types, constants and functions of the double-sided crystal ball evaluator.
package dscb_pkg;

    localparam int FRAC_BITS = 16;

    localparam int X_W      = 32;
    localparam int ALPHA_W  = 24;
    localparam int SIGMA_W  = 31;
    localparam int AMP_W    = 32;
    localparam int DIFF_W   = X_W + 1;
    localparam int QW       = X_W + FRAC_BITS;
    localparam int TM_W     = 4 + FRAC_BITS;
    localparam int OP_W     = (TM_W > ALPHA_W) ? TM_W : ALPHA_W;
    localparam int SQ_W     = 2 * OP_W;
    localparam int NF_W     = ALPHA_W + FRAC_BITS;
    localparam int LOG_IN_W = ALPHA_W + QW + 1;
    localparam int LOG_P_W  = $clog2(LOG_IN_W);
    localparam int LOG_F_W  = 32;
    localparam int LOG_W    = LOG_P_W + LOG_F_W;
    localparam int E_INT_W  = 6;
    localparam int HS_W     = E_INT_W + 32 + 1;
    localparam int L2E_W    = 25;
    localparam int EL_W     = HS_W + L2E_W - 24;
    localparam int NLB_W    = ALPHA_W + LOG_W;
    localparam int E_TAIL_W = NLB_W - FRAC_BITS;
    localparam int E_W      = ((EL_W > E_TAIL_W) ? EL_W : E_TAIL_W) + 1;
    localparam int MANT_W   = 33;

    localparam int DIV_STAGES = QW;
    localparam int LOG_STAGES = 2 + LOG_F_W;
    localparam int EXP_STAGES = 32;

    localparam logic [L2E_W-1:0] L2E_Q24 = 25'd24204406;
    localparam logic [63:0]      E_LIMIT = 64'd1 << (E_INT_W + 32);

    localparam logic [1:0] REGION_CORE = 2'd0;
    localparam logic [1:0] REGION_LOW  = 2'd1;
    localparam logic [1:0] REGION_HIGH = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_POSITION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE     = 3'd6;

    typedef struct packed {
        logic [1:0]         region;
        logic [ALPHA_W-1:0] a;
        logic [ALPHA_W-1:0] n;
    } div_side_t;

    typedef struct packed {
        logic [1:0]         region;
        logic               far;
        logic [EL_W-1:0]    el;
        logic [ALPHA_W-1:0] n;
    } log_side_t;

    typedef struct packed {
        logic [1:0]         region;
        logic               zero;
        logic [E_INT_W-1:0] k;
    } exp_side_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = '0;
        b   = 64'h4000_0000_0000_0000;
        rem = v;
        for (int j = 0; j < 32; j++)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // i-th repeated square root of one half, Q0.32
    function automatic logic [31:0] root_const(input int i);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int j = 1; j <= i; j++)
        begin
            c = isqrt64(c << 32);
        end
        return c[31:0];
    endfunction

    function automatic logic [63:0] half_sq(input logic [SQ_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        if (2 * FRAC_BITS >= 31)
            return w >> (2 * FRAC_BITS - 31);
        else
            return w << (31 - 2 * FRAC_BITS);
    endfunction

endpackage

// ===== rtl/core/dscb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module dscb_div
    import dscb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic [QW-1:0]      dividend,
    input  logic [SIGMA_W-1:0] divisor,
    input  div_side_t          in_side,
    output logic               out_vld,
    output logic [QW-1:0]      quotient,
    output div_side_t          out_side
);

    localparam int ACC_W = SIGMA_W + QW;

    logic              vld_reg  [DIV_STAGES];
    logic [ACC_W-1:0]  acc_reg  [DIV_STAGES];
    div_side_t         side_reg [DIV_STAGES];
    logic [ACC_W-1:0]  acc_next [DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : g_stage
            localparam int PREV = (g > 0) ? g - 1 : 0;
            logic [ACC_W-1:0] prev;
            logic [ACC_W:0]   shifted;
            logic [SIGMA_W:0] top;
            logic             vin;
            div_side_t        sin;

            always_comb
            begin
                if (g == 0)
                begin
                    prev = {{SIGMA_W{1'b0}}, dividend};
                    vin  = in_vld;
                    sin  = in_side;
                end
                else
                begin
                    prev = acc_reg[PREV];
                    vin  = vld_reg[PREV];
                    sin  = side_reg[PREV];
                end
                shifted = {prev, 1'b0};
                top     = shifted[ACC_W:QW];
                if (top >= {1'b0, divisor})
                begin
                    top         = top - {1'b0, divisor};
                    acc_next[g] = {top[SIGMA_W-1:0], shifted[QW-1:1], 1'b1};
                end
                else
                begin
                    acc_next[g] = {top[SIGMA_W-1:0], shifted[QW-1:1], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else
                    vld_reg[g] <= vin;
            end

            always_ff @(posedge clk)
            begin
                acc_reg[g]  <= acc_next[g];
                side_reg[g] <= sin;
            end
        end
    endgenerate

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign quotient = acc_reg[DIV_STAGES-1][QW-1:0];
    assign out_side = side_reg[DIV_STAGES-1];

endmodule

// ===== rtl/core/dscb_log2.sv =====
// Two-lane pipelined log2: leading-one search, normalize, one squaring per fraction bit.
module dscb_log2
    import dscb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  logic [LOG_IN_W-1:0] val_a,
    input  logic [LOG_IN_W-1:0] val_b,
    input  log_side_t           in_side,
    output logic                out_vld,
    output logic [LOG_W-1:0]    log_a,
    output logic [LOG_W-1:0]    log_b,
    output log_side_t           out_side
);

    function automatic logic [LOG_P_W-1:0] msb_pos(input logic [LOG_IN_W-1:0] v);
        logic [LOG_P_W-1:0] p;
        p = '0;
        for (int i = 0; i < LOG_IN_W; i++)
        begin
            if (v[i])
                p = LOG_P_W'(i);
        end
        return p;
    endfunction

    logic [LOG_IN_W-1:0] val_next [2];

    // encode stage
    logic                enc_vld_reg;
    logic [LOG_IN_W-1:0] enc_val_reg  [2];
    logic [LOG_P_W-1:0]  enc_p_reg    [2];
    log_side_t           enc_side_reg;

    // normalize stage
    logic                nrm_vld_reg;
    logic [31:0]         nrm_m_reg    [2];
    logic [LOG_P_W-1:0]  nrm_p_reg    [2];
    log_side_t           nrm_side_reg;
    logic [31:0]         nrm_m_next   [2];

    // squaring stages
    logic                sq_vld_reg  [LOG_F_W];
    logic [31:0]         sq_m_reg    [LOG_F_W][2];
    logic [LOG_F_W-1:0]  sq_f_reg    [LOG_F_W][2];
    logic [LOG_P_W-1:0]  sq_p_reg    [LOG_F_W][2];
    log_side_t           sq_side_reg [LOG_F_W];

    assign val_next[0] = val_a;
    assign val_next[1] = val_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_vld_reg <= 1'b0;
            nrm_vld_reg <= 1'b0;
        end
        else
        begin
            enc_vld_reg <= in_vld;
            nrm_vld_reg <= enc_vld_reg;
        end
    end

    genvar l, s;
    generate
        for (l = 0; l < 2; l++)
        begin : g_lane
            logic [LOG_IN_W+30:0] ext;

            always_comb
            begin
                ext           = {enc_val_reg[l], 31'b0};
                nrm_m_next[l] = 32'(ext >> enc_p_reg[l]);
            end

            always_ff @(posedge clk)
            begin
                enc_val_reg[l] <= val_next[l];
                enc_p_reg[l]   <= msb_pos(val_next[l]);
                nrm_m_reg[l]   <= nrm_m_next[l];
                nrm_p_reg[l]   <= enc_p_reg[l];
            end
        end

        for (s = 0; s < LOG_F_W; s++)
        begin : g_sq
            localparam int PREV = (s > 0) ? s - 1 : 0;
            logic vin;
            log_side_t sin;

            always_comb
            begin
                if (s == 0)
                begin
                    vin = nrm_vld_reg;
                    sin = nrm_side_reg;
                end
                else
                begin
                    vin = sq_vld_reg[PREV];
                    sin = sq_side_reg[PREV];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sq_vld_reg[s] <= 1'b0;
                else
                    sq_vld_reg[s] <= vin;
            end

            always_ff @(posedge clk)
            begin
                sq_side_reg[s] <= sin;
            end

            for (l = 0; l < 2; l++)
            begin : g_ln
                logic [31:0]        m_in;
                logic [LOG_F_W-1:0] f_in;
                logic [LOG_P_W-1:0] p_in;
                logic [63:0]        sq;
                logic [32:0]        sh;
                logic [31:0]        m_next;
                logic [LOG_F_W-1:0] f_next;

                always_comb
                begin
                    if (s == 0)
                    begin
                        m_in = nrm_m_reg[l];
                        f_in = '0;
                        p_in = nrm_p_reg[l];
                    end
                    else
                    begin
                        m_in = sq_m_reg[PREV][l];
                        f_in = sq_f_reg[PREV][l];
                        p_in = sq_p_reg[PREV][l];
                    end
                    sq = 64'(m_in) * 64'(m_in);
                    sh = sq[63:31];
                    if (sh[32])
                    begin
                        m_next = sh[32:1];
                        f_next = {f_in[LOG_F_W-2:0], 1'b1};
                    end
                    else
                    begin
                        m_next = sh[31:0];
                        f_next = {f_in[LOG_F_W-2:0], 1'b0};
                    end
                end

                always_ff @(posedge clk)
                begin
                    sq_m_reg[s][l] <= m_next;
                    sq_f_reg[s][l] <= f_next;
                    sq_p_reg[s][l] <= p_in;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        enc_side_reg <= in_side;
        nrm_side_reg <= enc_side_reg;
    end

    assign out_vld  = sq_vld_reg[LOG_F_W-1];
    assign log_a    = {sq_p_reg[LOG_F_W-1][0], sq_f_reg[LOG_F_W-1][0]};
    assign log_b    = {sq_p_reg[LOG_F_W-1][1], sq_f_reg[LOG_F_W-1][1]};
    assign out_side = sq_side_reg[LOG_F_W-1];

endmodule

// ===== rtl/core/dscb_exp2.sv =====
// Pipelined 2^-f: one constant root multiply per fraction bit.
module dscb_exp2
    import dscb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [31:0]       frac,
    input  exp_side_t         in_side,
    output logic              out_vld,
    output logic [MANT_W-1:0] mant,
    output exp_side_t         out_side
);

    logic              vld_reg  [EXP_STAGES];
    logic [MANT_W-1:0] m_reg    [EXP_STAGES];
    logic [31:0]       f_reg    [EXP_STAGES];
    exp_side_t         side_reg [EXP_STAGES];

    genvar g;
    generate
        for (g = 0; g < EXP_STAGES; g++)
        begin : g_stage
            localparam logic [31:0] ROOT = root_const(g + 1);
            localparam int PREV = (g > 0) ? g - 1 : 0;
            logic              vin;
            logic [MANT_W-1:0] m_in;
            logic [31:0]       f_in;
            exp_side_t         sin;
            logic [MANT_W+31:0] prod;
            logic [MANT_W-1:0] m_next;

            always_comb
            begin
                if (g == 0)
                begin
                    vin  = in_vld;
                    m_in = MANT_W'(64'd1 << 32);
                    f_in = frac;
                    sin  = in_side;
                end
                else
                begin
                    vin  = vld_reg[PREV];
                    m_in = m_reg[PREV];
                    f_in = f_reg[PREV];
                    sin  = side_reg[PREV];
                end
                prod = (MANT_W+32)'(m_in) * (MANT_W+32)'(ROOT);
                if (f_in[31-g])
                    m_next = MANT_W'(prod >> 32);
                else
                    m_next = m_in;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else
                    vld_reg[g] <= vin;
            end

            always_ff @(posedge clk)
            begin
                m_reg[g]    <= m_next;
                f_reg[g]    <= f_in;
                side_reg[g] <= sin;
            end
        end
    endgenerate

    assign out_vld  = vld_reg[EXP_STAGES-1];
    assign mant     = m_reg[EXP_STAGES-1];
    assign out_side = side_reg[EXP_STAGES-1];

endmodule

// ===== rtl/core/double_sided_crystal_ball_eval.sv =====
// Top level of the double-sided crystal ball evaluator: config, region, tail math, output.
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+------------------------------
//  input   | x_value                              | start && !busy
//  result  | shape_value, region, saturated       | done, one cycle, no backpressure
//  config  | cfg_index, cfg_data                  | cfg_valid && cfg_ready
//
//  One item per cycle; the pipeline takes new items while earlier ones are still in flight.
//  Each item passes through the 48-stage divider, the 34-stage log2 and the 32-stage exp2.
//  busy stays low and cfg_ready stays high; the pipeline never stalls.
//  Reset clears the valid bits and loads the default shape.
module double_sided_crystal_ball_eval
    import dscb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [X_W-1:0] x_value,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 done,
    output logic [31:0]          shape_value,
    output logic [1:0]           region,
    output logic                 saturated
);

    localparam int LATENCY = 11 + DIV_STAGES + LOG_STAGES + EXP_STAGES;
    localparam int AS_W = ALPHA_W + SIGMA_W;

    logic in_acc;

    logic [ALPHA_W-1:0] alpha_low_reg, alpha_high_reg, exp_low_reg, exp_high_reg;
    logic [X_W-1:0]     peak_reg;
    logic [SIGMA_W-1:0] width_reg;
    logic [AMP_W-1:0]   amp_reg;
    logic [SIGMA_W-1:0] sigma;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_acc    = start && !busy;
    assign sigma     = (width_reg == '0) ? SIGMA_W'(1) : width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= ALPHA_W'(65536);
            alpha_high_reg <= ALPHA_W'(65536);
            exp_low_reg    <= ALPHA_W'(131072);
            exp_high_reg   <= ALPHA_W'(131072);
            peak_reg       <= '0;
            width_reg      <= SIGMA_W'(65536);
            amp_reg        <= AMP_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ALPHA_LOW:     alpha_low_reg  <= cfg_data[ALPHA_W-1:0];
                CFG_ALPHA_HIGH:    alpha_high_reg <= cfg_data[ALPHA_W-1:0];
                CFG_EXPONENT_LOW:  exp_low_reg    <= cfg_data[ALPHA_W-1:0];
                CFG_EXPONENT_HIGH: exp_high_reg   <= cfg_data[ALPHA_W-1:0];
                CFG_PEAK_POSITION: peak_reg       <= cfg_data[X_W-1:0];
                CFG_CORE_WIDTH:    width_reg      <= cfg_data[SIGMA_W-1:0];
                CFG_AMPLITUDE:     amp_reg        <= cfg_data[AMP_W-1:0];
                default:           ;
            endcase
        end
    end

    // S1: difference and threshold products
    logic              s1_vld_reg;
    logic [DIFF_W-1:0] s1_diff_reg, s1_diff_next;
    logic [AS_W-1:0]   s1_as_low_reg, s1_as_high_reg;

    assign s1_diff_next = {x_value[X_W-1], x_value} - {peak_reg[X_W-1], peak_reg};

    // S2: region decision
    logic              s2_vld_reg;
    logic [QW-1:0]     s2_scaled_reg, s2_scaled_next;
    div_side_t         s2_side_reg, s2_side_next;

    always_comb
    begin
        logic [DIFF_W-1:0] neg_diff;
        logic [X_W-1:0]    mag;
        logic [ALPHA_W-1:0] n_sel;
        neg_diff       = -s1_diff_reg;
        mag            = s1_diff_reg[DIFF_W-1] ? neg_diff[X_W-1:0] : s1_diff_reg[X_W-1:0];
        s2_scaled_next = {mag, {FRAC_BITS{1'b0}}};
        if (s1_diff_reg[DIFF_W-1] && 64'(s2_scaled_next) > 64'(s1_as_low_reg))
        begin
            s2_side_next.region = REGION_LOW;
            s2_side_next.a      = alpha_low_reg;
            n_sel               = exp_low_reg;
        end
        else if (!s1_diff_reg[DIFF_W-1] && 64'(s2_scaled_next) > 64'(s1_as_high_reg))
        begin
            s2_side_next.region = REGION_HIGH;
            s2_side_next.a      = alpha_high_reg;
            n_sel               = exp_high_reg;
        end
        else
        begin
            s2_side_next.region = REGION_CORE;
            s2_side_next.a      = alpha_low_reg;
            n_sel               = exp_low_reg;
        end
        s2_side_next.n = (n_sel == '0) ? ALPHA_W'(1) : n_sel;
    end

    logic          dv_vld;
    logic [QW-1:0] dv_q;
    div_side_t     dv_side;

    dscb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s2_vld_reg),
        .dividend (s2_scaled_reg),
        .divisor  (sigma),
        .in_side  (s2_side_reg),
        .out_vld  (dv_vld),
        .quotient (dv_q),
        .out_side (dv_side)
    );

    // T1: tail offset, square operand, far-core flag
    logic            t1_vld_reg;
    logic [QW-1:0]   t1_d_reg, t1_d_next;
    logic [OP_W-1:0] t1_op_reg, t1_op_next;
    logic            t1_far_reg, t1_far_next;
    div_side_t       t1_side_reg;

    assign t1_d_next   = dv_q - QW'(dv_side.a);
    assign t1_op_next  = (dv_side.region == REGION_CORE) ? OP_W'(dv_q[TM_W-1:0])
                                                         : OP_W'(dv_side.a);
    assign t1_far_next = |dv_q[QW-1:TM_W];

    // T2: products
    logic                        t2_vld_reg;
    logic [SQ_W-1:0]             t2_sq_reg, t2_sq_next;
    logic [ALPHA_W+31:0]         t2_plo_reg, t2_plo_next;
    logic [ALPHA_W+QW-33:0]      t2_phi_reg, t2_phi_next;
    logic                        t2_far_reg;
    div_side_t                   t2_side_reg;

    assign t2_sq_next  = SQ_W'(t1_op_reg) * SQ_W'(t1_op_reg);
    assign t2_plo_next = (ALPHA_W+32)'(t1_side_reg.a) * (ALPHA_W+32)'(t1_d_reg[31:0]);
    assign t2_phi_next = (ALPHA_W+QW-32)'(t1_side_reg.a) * (ALPHA_W+QW-32)'(t1_d_reg[QW-1:32]);

    // T3: log argument and natural-to-log2 product
    logic                t3_vld_reg;
    logic [LOG_IN_W-1:0] t3_v_reg, t3_v_next;
    logic [NF_W-1:0]     t3_nf_reg, t3_nf_next;
    logic [63:0]         t3_lm_reg, t3_lm_next;
    logic                t3_far_reg;
    div_side_t           t3_side_reg;

    always_comb
    begin
        logic [63:0]     hs;
        logic [HS_W-1:0] hs_c;
        hs         = half_sq(t2_sq_reg);
        hs_c       = (hs > E_LIMIT) ? HS_W'(E_LIMIT) : HS_W'(hs);
        t3_lm_next = 64'(hs_c) * 64'(L2E_Q24);
        t3_nf_next = {t2_side_reg.n, {FRAC_BITS{1'b0}}};
        t3_v_next  = (LOG_IN_W'(t2_phi_reg) << 32) + LOG_IN_W'(t2_plo_reg)
                   + LOG_IN_W'(t3_nf_next);
    end

    // T4: scale down the log2 product
    logic                t4_vld_reg;
    logic [LOG_IN_W-1:0] t4_v_reg;
    logic [NF_W-1:0]     t4_nf_reg;
    log_side_t           t4_side_reg, t4_side_next;

    assign t4_side_next.region = t3_side_reg.region;
    assign t4_side_next.far    = t3_far_reg;
    assign t4_side_next.el     = EL_W'(t3_lm_reg >> 24);
    assign t4_side_next.n      = t3_side_reg.n;

    logic             lg_vld;
    logic [LOG_W-1:0] lg_n, lg_d;
    log_side_t        lg_side;

    dscb_log2 u_log2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (t4_vld_reg),
        .val_a    (t4_v_reg),
        .val_b    (LOG_IN_W'(t4_nf_reg)),
        .in_side  (t4_side_reg),
        .out_vld  (lg_vld),
        .log_a    (lg_n),
        .log_b    (lg_d),
        .out_side (lg_side)
    );

    // E1..E3: exponent assembly
    logic             e1_vld_reg;
    logic [LOG_W-1:0] e1_lb_reg, e1_lb_next;
    log_side_t        e1_side_reg;

    assign e1_lb_next = (lg_n > lg_d) ? (lg_n - lg_d) : '0;

    logic             e2_vld_reg;
    logic [NLB_W-1:0] e2_nlb_reg, e2_nlb_next;
    log_side_t        e2_side_reg;

    assign e2_nlb_next = NLB_W'(e1_side_reg.n) * NLB_W'(e1_lb_reg);

    logic        e3_vld_reg;
    logic [31:0] e3_f_reg;
    exp_side_t   e3_side_reg, e3_side_next;
    logic [E_W-1:0] e_sum;

    always_comb
    begin
        if (e2_side_reg.region == REGION_CORE)
            e_sum = e2_side_reg.far ? E_W'(E_LIMIT) : E_W'(e2_side_reg.el);
        else
            e_sum = E_W'(e2_side_reg.el) + E_W'(e2_nlb_reg >> FRAC_BITS);
        e3_side_next.region = e2_side_reg.region;
        e3_side_next.zero   = (64'(e_sum) >= E_LIMIT);
        e3_side_next.k      = e_sum[32 +: E_INT_W];
    end

    logic              ex_vld;
    logic [MANT_W-1:0] ex_m;
    exp_side_t         ex_side;

    dscb_exp2 u_exp2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (e3_vld_reg),
        .frac     (e3_f_reg),
        .in_side  (e3_side_reg),
        .out_vld  (ex_vld),
        .mant     (ex_m),
        .out_side (ex_side)
    );

    // P1: scale by norm; P2: shift, round, clip
    logic        p1_vld_reg;
    logic [63:0] p1_prod_reg, p1_prod_next;
    exp_side_t   p1_side_reg;

    assign p1_prod_next = 64'(65'(amp_reg) * 65'(ex_m));

    logic        done_reg;
    logic [31:0] shape_reg, shape_next;
    logic [1:0]  region_reg;
    logic        sat_reg, sat_next;

    always_comb
    begin
        logic [31:0] hi;
        logic [5:0]  rnd_idx;
        logic [32:0] res;
        hi      = p1_prod_reg[63:32] >> p1_side_reg.k[4:0];
        rnd_idx = 6'd31 + {1'b0, p1_side_reg.k[4:0]};
        if (p1_side_reg.zero || p1_side_reg.k[5])
            res = '0;
        else
            res = {1'b0, hi} + {32'b0, p1_prod_reg[rnd_idx]};
        sat_next   = res[32];
        shape_next = res[32] ? 32'hFFFF_FFFF : res[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            t1_vld_reg <= 1'b0;
            t2_vld_reg <= 1'b0;
            t3_vld_reg <= 1'b0;
            t4_vld_reg <= 1'b0;
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_acc;
            s2_vld_reg <= s1_vld_reg;
            t1_vld_reg <= dv_vld;
            t2_vld_reg <= t1_vld_reg;
            t3_vld_reg <= t2_vld_reg;
            t4_vld_reg <= t3_vld_reg;
            e1_vld_reg <= lg_vld;
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
            p1_vld_reg <= ex_vld;
            done_reg   <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_diff_reg    <= s1_diff_next;
        s1_as_low_reg  <= AS_W'(alpha_low_reg) * AS_W'(sigma);
        s1_as_high_reg <= AS_W'(alpha_high_reg) * AS_W'(sigma);
        s2_scaled_reg  <= s2_scaled_next;
        s2_side_reg    <= s2_side_next;
        t1_d_reg       <= t1_d_next;
        t1_op_reg      <= t1_op_next;
        t1_far_reg     <= t1_far_next;
        t1_side_reg    <= dv_side;
        t2_sq_reg      <= t2_sq_next;
        t2_plo_reg     <= t2_plo_next;
        t2_phi_reg     <= t2_phi_next;
        t2_far_reg     <= t1_far_reg;
        t2_side_reg    <= t1_side_reg;
        t3_v_reg       <= t3_v_next;
        t3_nf_reg      <= t3_nf_next;
        t3_lm_reg      <= t3_lm_next;
        t3_far_reg     <= t2_far_reg;
        t3_side_reg    <= t2_side_reg;
        t4_v_reg       <= t3_v_reg;
        t4_nf_reg      <= t3_nf_reg;
        t4_side_reg    <= t4_side_next;
        e1_lb_reg      <= e1_lb_next;
        e1_side_reg    <= lg_side;
        e2_nlb_reg     <= e2_nlb_next;
        e2_side_reg    <= e1_side_reg;
        e3_f_reg       <= e_sum[31:0];
        e3_side_reg    <= e3_side_next;
        p1_prod_reg    <= p1_prod_next;
        p1_side_reg    <= ex_side;
        shape_reg      <= shape_next;
        region_reg     <= p1_side_reg.region;
        sat_reg        <= sat_next;
    end

    assign done        = done_reg;
    assign shape_value = shape_reg;
    assign region      = region_reg;
    assign saturated   = sat_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> ##LATENCY done)
        else $error("accepted item produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_acc, LATENCY))
        else $error("result without a matching item");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> shape_value == 32'hFFFF_FFFF)
        else $error("saturated result not clipped");

endmodule

// ===== test/double_sided_crystal_ball_eval_test.sv =====
// Testbench for the double-sided crystal ball evaluator: predicts each sample and checks results.
`timescale 1ns / 100ps

module double_sided_crystal_ball_eval_test;
    import dscb_pkg::*;

    localparam int LATENCY = 125;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [63:0] LOG2E_Q24 = 64'd24204406;
    localparam logic [63:0] E_CAP = 64'd64 << 32;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  region;
        logic        saturated;
    } sample_result_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [X_W-1:0] x_value;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;
    logic done;
    logic [31:0] shape_value;
    logic [1:0] region;
    logic saturated;

    logic [63:0] alpha_lo_q, alpha_hi_q, expo_lo_q, expo_hi_q, peak_q, width_q, amp_q;

    logic [31:0]    pending_x[$];
    sample_result_t expected_results[$];
    logic [CFG_IDX_W-1:0] write_index_q[$];
    logic [31:0]    write_data_q[$];

    int mismatches;
    int checked;
    int cycles;
    int send_idle_pct;
    int tail_count[3];
    int sat_count;

    double_sided_crystal_ball_eval u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .x_value(x_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .shape_value(shape_value), .region(region),
        .saturated(saturated)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] log2_fixed(input logic [127:0] v);
        int p;
        logic [63:0] m;
        logic [63:0] frac;
        logic [127:0] mm;
        if (v == 0)
            return 0;
        p = 0;
        for (int i = 127; i >= 0; i--)
        begin
            if (v[i])
            begin
                p = i;
                break;
            end
        end
        if (p >= 31)
            mm = v >> (p - 31);
        else
            mm = v << (31 - p);
        m = {32'd0, mm[31:0]};
        frac = 0;
        for (int i = 31; i >= 0; i--)
        begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32))
            begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return (64'(p) << 32) | frac;
    endfunction

    function automatic logic [63:0] nat_to_log2(input logic [63:0] q);
        logic [127:0] w;
        if (q > E_CAP)
            q = E_CAP;
        w = 128'(q) * 128'(LOG2E_Q24);
        return 64'(w >> 24);
    endfunction

    function automatic sample_result_t predict_shape(input logic [31:0] xv);
        logic signed [63:0] diff;
        logic [63:0] mag, sigma, scaled, e, res, a, n, d, p1, p2, nf, ln, ld, lb, tm;
        logic [127:0] num, prod, nlb;
        logic [63:0] k, f, m, c;
        logic [1:0] reg_sel;
        logic sat;
        int s;
        diff = 64'($signed(xv)) - 64'($signed(peak_q[31:0]));
        mag = diff < 0 ? 64'(-diff) : 64'(diff);
        sigma = width_q != 0 ? width_q : 64'd1;
        scaled = mag << FRAC_BITS;
        reg_sel = REGION_CORE;
        sat = 1'b0;
        if (diff < 0 && scaled > alpha_lo_q * sigma)
            reg_sel = REGION_LOW;
        else if (diff > 0 && scaled > alpha_hi_q * sigma)
            reg_sel = REGION_HIGH;
        if (reg_sel == REGION_CORE)
        begin
            tm = scaled / sigma;
            if (tm >= (64'd16 << FRAC_BITS))
                e = E_CAP;
            else
                e = nat_to_log2((tm * tm) >> (2 * FRAC_BITS - 31));
        end
        else
        begin
            a = reg_sel == REGION_LOW ? alpha_lo_q : alpha_hi_q;
            n = reg_sel == REGION_LOW ? expo_lo_q : expo_hi_q;
            if (n == 0)
                n = 1;
            d = (scaled - a * sigma) / sigma;
            p1 = a * {32'd0, d[31:0]};
            p2 = a * (d >> 32);
            nf = n << FRAC_BITS;
            num = (128'(p2) << 32) + 128'(p1) + 128'(nf);
            ln = log2_fixed(num);
            ld = log2_fixed(128'(nf));
            lb = ln > ld ? ln - ld : 64'd0;
            nlb = 128'(n) * 128'(lb);
            e = nat_to_log2((a * a) >> (2 * FRAC_BITS - 31)) + 64'(nlb >> FRAC_BITS);
        end
        if (e >= E_CAP)
            res = 0;
        else
        begin
            k = e >> 32;
            f = e & 64'hFFFF_FFFF;
            m = 64'd1 << 32;
            c = 64'd1 << 31;
            for (int i = 1; i <= 32; i++)
            begin
                c = int_sqrt(c << 32);
                if (f[32-i])
                    m = (m * c) >> 32;
            end
            prod = 128'(amp_q) * 128'(m);
            s = 32 + int'(k);
            if (s >= 64)
                res = 0;
            else
                res = 64'(prod >> s) + 64'((prod >> (s - 1)) & 1);
        end
        if (res > 64'hFFFF_FFFF)
        begin
            res = 64'hFFFF_FFFF;
            sat = 1'b1;
        end
        return '{value: res[31:0], region: reg_sel, saturated: sat};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, checked);
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        case (idx)
            CFG_ALPHA_LOW:     alpha_lo_q = {40'd0, val[23:0]};
            CFG_ALPHA_HIGH:    alpha_hi_q = {40'd0, val[23:0]};
            CFG_EXPONENT_LOW:  expo_lo_q  = {40'd0, val[23:0]};
            CFG_EXPONENT_HIGH: expo_hi_q  = {40'd0, val[23:0]};
            CFG_PEAK_POSITION: peak_q     = {32'd0, val};
            CFG_CORE_WIDTH:    width_q    = {33'd0, val[30:0]};
            CFG_AMPLITUDE:     amp_q      = {32'd0, val};
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            x_value <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (start && !busy)
                expected_results.push_back(predict_shape(x_value));
            if (cfg_valid && !cfg_ready)
                ;
            else if (write_index_q.size() > 0)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= write_index_q.pop_front();
                cfg_data <= write_data_q.pop_front();
            end
            else
                cfg_valid <= 1'b0;
            if (start && busy)
                ;
            else if (pending_x.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                start <= 1'b1;
                x_value <= pending_x.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("double_sided_crystal_ball_eval_test NOT OK");
            $finish;
        end
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", shape_value, 32'd0);
            else
            begin
                sample_result_t want;
                want = expected_results.pop_front();
                if (shape_value !== want.value)
                    report_mismatch("shape_value", shape_value, want.value);
                if (region !== want.region)
                    report_mismatch("region", 32'(region), 32'(want.region));
                if (saturated !== want.saturated)
                    report_mismatch("saturated", 32'(saturated), 32'(want.saturated));
                tail_count[want.region]++;
                if (want.saturated)
                    sat_count++;
            end
            checked++;
        end
    end

    task automatic wait_drained();
        while (pending_x.size() > 0 || start || expected_results.size() > 0
               || write_index_q.size() > 0 || cfg_valid)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        write_index_q.push_back(idx);
        write_data_q.push_back(val);
    endtask

    task automatic write_shape(input logic [23:0] al, input logic [23:0] ah,
                               input logic [23:0] nl, input logic [23:0] nh,
                               input logic [31:0] mu, input logic [30:0] sg,
                               input logic [31:0] nm);
        queue_write(CFG_ALPHA_LOW, {8'd0, al});
        queue_write(CFG_ALPHA_HIGH, {8'd0, ah});
        queue_write(CFG_EXPONENT_LOW, {8'd0, nl});
        queue_write(CFG_EXPONENT_HIGH, {8'd0, nh});
        queue_write(CFG_PEAK_POSITION, mu);
        queue_write(CFG_CORE_WIDTH, {1'b0, sg});
        queue_write(CFG_AMPLITUDE, nm);
        wait_drained();
    endtask

    function automatic logic [31:0] near_peak_x();
        logic [63:0] span;
        logic signed [63:0] off;
        span = width_q * 64'($urandom_range(8, 1));
        if (span > 64'h7FFF_FFFF)
            span = 64'h7FFF_FFFF;
        off = $signed(64'($urandom_range(32'(span)))) - $signed(64'(span >> 1)) * 2;
        if ($urandom_range(1))
            off = -off;
        return 32'($signed(peak_q[31:0]) + off);
    endfunction

    task automatic random_phase(input int count, input int idle_pct);
        send_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
                pending_x.push_back($urandom());
            else
                pending_x.push_back(near_peak_x());
        end
        wait_drained();
    endtask

    initial
    begin
        mismatches = 0;
        checked = 0;
        cycles = 0;
        send_idle_pct = 0;
        sat_count = 0;
        tail_count = '{0, 0, 0};
        alpha_lo_q = 65536;
        alpha_hi_q = 65536;
        expo_lo_q = 131072;
        expo_hi_q = 131072;
        peak_q = 0;
        width_q = 65536;
        amp_q = 65536;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (pending_x[i]) ;
        pending_x = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                      32'hFFFF_0000, 32'h0001_0001, 32'hFFFE_FFFF, 32'h0010_0000,
                      32'hFFF0_0000, 32'h000F_FFFF, 32'h0000_0001, 32'hFFFF_FFFF};
        wait_drained();

        write_shape(24'd0, 24'd0, 24'd0, 24'd0, 32'h0000_0000, 31'd0, 32'hFFFF_FFFF);
        pending_x = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h0000_0010};
        wait_drained();

        write_shape(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'h7FFF_FFFF,
                    31'h7FFF_FFFF, 32'hFFFF_FFFF);
        pending_x = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hC000_0000};
        wait_drained();

        write_shape(24'h010000, 24'h020000, 24'h020000, 24'h050000, 32'h0000_0000,
                    31'h0001_0000, 32'h0100_0000);
        random_phase(100, 0);
        random_phase(60, 66);
        write_shape(24'h008000, 24'h030000, 24'h000100, 24'h100000, 32'h8000_0000,
                    31'h0000_4000, 32'h0000_1000);
        random_phase(60, 20);
        write_shape(24'h1A0000, 24'h002000, 24'h640000, 24'h018000, 32'hFFF0_0000,
                    31'h0040_0000, 32'h4000_0000);
        random_phase(60, 66);
        for (int i = 0; i < 4; i++)
        begin
            write_shape(24'($urandom_range(24'hFFFFFF, 1)), 24'($urandom_range(24'hFFFFFF, 1)),
                        24'($urandom_range(24'hFFFFFF, 1)), 24'($urandom_range(24'hFFFFFF, 1)),
                        $urandom(), 31'($urandom_range(32'h7FFF_FFFF, 1)), $urandom());
            random_phase(30, i * 20);
        end

        $display("checked %0d results: core %0d, low tail %0d, high tail %0d, clipped %0d",
                 checked, tail_count[0], tail_count[1], tail_count[2], sat_count);
        $display("covered register extremes, zero sigma/alpha/exponent and random idling");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("double_sided_crystal_ball_eval_test OK");
        else
            $display("double_sided_crystal_ball_eval_test NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dscb_pkg.sv
rtl/core/dscb_div.sv
rtl/core/dscb_log2.sv
rtl/core/dscb_exp2.sv
rtl/core/double_sided_crystal_ball_eval.sv
test/double_sided_crystal_ball_eval_test.sv
